### src/cbs_pkg.sv
// ----------------------------------------------------------------------------
// cbs_pkg: shared types, constants and helpers of the checksummed byte store
// Command and programming-mode codes, field widths, the result record and
// the mode/checksum helper functions used by the store datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cbs_pkg;

   // Store size in bytes; must be a power of two (addresses wrap by masking).
   localparam int STORE_BYTES = 2048;
   localparam int STORE_AW    = $clog2(STORE_BYTES);

   // Item field widths
   localparam int CMD_W       = 2;
   localparam int ADDR_W      = 11;
   localparam int BYTE_W      = 8;
   localparam int MODE_W      = 2;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 16;

   localparam logic [BYTE_W-1:0] ERASED_BYTE = 8'hFF;

   typedef enum logic [CMD_W-1:0] {
      CMD_READ          = 2'd0,
      CMD_WRITE         = 2'd1,
      CMD_RECORD_WRITE  = 2'd2,
      CMD_RECORD_VERIFY = 2'd3
   } command_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_NONE        = 2'd0,
      MODE_ERASE_WRITE = 2'd1,
      MODE_ERASE_ONLY  = 2'd2,
      MODE_WRITE_ONLY  = 2'd3
   } mode_type;

   typedef struct packed {
      logic               record_done;
      logic               checksum_ok;
      mode_type           checksum_mode;
      mode_type           program_mode;
      logic [BYTE_W-1:0]  read_data;
   } rsp_item_type;

   // Cheapest programming mode to turn old_b into new_b.
   function automatic mode_type pick_mode(input logic [BYTE_W-1:0] old_b,
                                          input logic [BYTE_W-1:0] new_b);
      logic [BYTE_W-1:0] diff;
      mode_type          mode;
      diff = old_b ^ new_b;
      if ((diff & new_b) != '0) begin
         mode = (new_b != ERASED_BYTE) ? MODE_ERASE_WRITE : MODE_ERASE_ONLY;
      end else if (diff != '0) begin
         mode = MODE_WRITE_ONLY;
      end else begin
         mode = MODE_NONE;
      end
      return mode;
   endfunction

   // Rotate left by one, then add the byte modulo 256.
   function automatic logic [BYTE_W-1:0] fold(input logic [BYTE_W-1:0] sum,
                                              input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] rot;
      rot = {sum[BYTE_W-2:0], sum[BYTE_W-1]};
      return rot + b;
   endfunction

   // Byte address to store index (wrap modulo the power-of-two store size).
   function automatic logic [STORE_AW-1:0] to_index(input logic [ADDR_W-1:0] a);
      logic [31:0] wide;
      wide = 32'(a);
      return wide[STORE_AW-1:0];
   endfunction

endpackage

`default_nettype wire

### src/checksummed_byte_store_unit.sv
// ----------------------------------------------------------------------------
// checksummed_byte_store_unit: byte store with split erase/write reporting
// and a rotate-add record checksum
//
//   channel  | dir | handshake              | payload
//   ---------+-----+------------------------+---------------------------------
//   req_     | in  | req_tvalid/req_tready  | tdata: command, address, data
//            |     |                        | tlast: last_byte
//   rsp_     | out | rsp_tvalid/rsp_tready  | tdata: read_data, program_mode,
//            |     |                        |   checksum_mode, checksum_ok
//            |     |                        | tlast: record_done
//
// Sequence: an item passes through accept, with the store read issued, then
// lookup with the write-back; the last byte of a record adds a check step
// reading the checksum byte at address plus one. This sequence is set by
// the single read port of the store RAM and its registered read data.
// Reset: a clearing pass writes zero to every one of the STORE_BYTES (2048)
// entries, one per cycle; req_tready stays low until it ends.
// Stalls: a result waits in the rsp register while the next item is
// accepted; if that register is still full when the next result is ready,
// the result is parked for as long as the stall lasts and no item is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module checksummed_byte_store_unit
   import cbs_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request channel
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // [1:0] command, [12:2] address, [20:13] data, [23:21] zero
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   input  wire logic                   req_tlast,
   // response channel
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // [7:0] read_data, [9:8] program_mode, [11:10] checksum_mode,
   // [12] checksum_ok, [15:13] zero
   output logic      [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                        rsp_tlast
);

   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_LOOKUP = 5'b00100,
      ST_CHECK  = 5'b01000,
      ST_EMIT   = 5'b10000
   } state_type;

   // control state
   state_type           state_ff,     state_in;
   logic [STORE_AW-1:0] clr_cnt_ff,   clr_cnt_in;
   logic [BYTE_W-1:0]   sum_ff,       sum_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // item and result payload
   command_type         cmd_ff;
   logic [STORE_AW-1:0] idx_ff;
   logic [BYTE_W-1:0]   data_ff;
   logic                last_ff;
   logic [BYTE_W-1:0]   part_rd_ff,   part_rd_in;
   mode_type            part_pm_ff,   part_pm_in;
   rsp_item_type        hold_ff,      hold_in;
   rsp_item_type        rsp_ff,       rsp_in;

   // store RAM port
   logic                ram_we;
   logic [STORE_AW-1:0] ram_waddr;
   logic [BYTE_W-1:0]   ram_wdata;
   logic                ram_re;
   logic [STORE_AW-1:0] ram_raddr;
   logic [BYTE_W-1:0]   ram_rdata;

   logic                req_accept;
   logic                out_free;
   logic [STORE_AW-1:0] req_idx;
   logic [STORE_AW-1:0] next_idx;
   logic [BYTE_W-1:0]   lookup_sum;
   rsp_item_type        fin;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_idx    = to_index(req_tdata[ADDR_W+CMD_W-1:CMD_W]);
   assign next_idx   = idx_ff + STORE_AW'(1);

   // fold the written byte for record write, the stored byte for verify
   assign lookup_sum = fold(sum_ff, (cmd_ff == CMD_RECORD_VERIFY) ? ram_rdata : data_ff);

   cbs_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (STORE_BYTES)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in       = rsp_ff;
      hold_in      = hold_ff;
      part_rd_in   = part_rd_ff;
      part_pm_in   = part_pm_ff;
      ram_we       = 1'b0;
      ram_waddr    = idx_ff;
      ram_wdata    = data_ff;
      ram_re       = 1'b0;
      ram_raddr    = req_idx;
      fin          = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            // sweep zeros through the whole store
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_ff;
            ram_wdata = '0;
            if (clr_cnt_ff == STORE_AW'(STORE_BYTES - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + STORE_AW'(1);
            end
         end

         ST_IDLE: begin
            // issue the read of the old byte as the item is accepted
            ram_re = req_tvalid;
            if (req_tvalid) begin
               state_in = ST_LOOKUP;
            end
         end

         ST_LOOKUP: begin
            unique case (cmd_ff)
               CMD_READ: begin
                  fin.read_data = ram_rdata;
               end
               CMD_WRITE: begin
                  ram_we           = 1'b1;
                  fin.program_mode = pick_mode(ram_rdata, data_ff);
               end
               CMD_RECORD_WRITE: begin
                  ram_we           = 1'b1;
                  fin.program_mode = pick_mode(ram_rdata, data_ff);
                  sum_in           = lookup_sum;
               end
               CMD_RECORD_VERIFY: begin
                  fin.read_data = ram_rdata;
                  sum_in        = lookup_sum;
               end
            endcase

            if (last_ff && (cmd_ff == CMD_RECORD_WRITE || cmd_ff == CMD_RECORD_VERIFY)) begin
               // fetch the stored checksum byte at address plus one
               ram_re     = 1'b1;
               ram_raddr  = next_idx;
               part_rd_in = fin.read_data;
               part_pm_in = fin.program_mode;
               state_in   = ST_CHECK;
            end else if (out_free) begin
               rsp_in       = fin;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               hold_in  = fin;
               state_in = ST_EMIT;
            end
         end

         ST_CHECK: begin
            // sum_ff already holds the checksum folded over the last byte
            fin.read_data    = part_rd_ff;
            fin.program_mode = part_pm_ff;
            fin.record_done  = 1'b1;
            if (cmd_ff == CMD_RECORD_WRITE) begin
               ram_we            = 1'b1;
               ram_waddr         = next_idx;
               ram_wdata         = sum_ff;
               fin.checksum_mode = pick_mode(ram_rdata, sum_ff);
            end else begin
               fin.checksum_ok = (sum_ff == ram_rdata);
            end
            sum_in = '0;
            if (out_free) begin
               rsp_in       = fin;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               hold_in  = fin;
               state_in = ST_EMIT;
            end
         end

         ST_EMIT: begin
            // drain the parked result once the rsp register frees up
            if (out_free) begin
               rsp_in       = hold_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff  <= command_type'(req_tdata[CMD_W-1:0]);
         idx_ff  <= req_idx;
         data_ff <= req_tdata[CMD_W+ADDR_W+BYTE_W-1:CMD_W+ADDR_W];
         last_ff <= req_tlast;
      end
      part_rd_ff <= part_rd_in;
      part_pm_ff <= part_pm_in;
      hold_ff    <= hold_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_ff.checksum_ok, rsp_ff.checksum_mode,
                        rsp_ff.program_mode, rsp_ff.read_data};
   assign rsp_tlast  = rsp_ff.record_done;

   // a write and a read of the store never target the same entry at once
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
      else $error("store read and write hit the same entry");

   // the running checksum restarts after every record
   a_sum_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |=> (sum_ff == '0))
      else $error("running checksum not cleared after record end");

   // nothing writes the store while waiting for an item
   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !ram_we)
      else $error("store written while idle");

endmodule

`default_nettype wire

### src/cbs_ram.sv
// ----------------------------------------------------------------------------
// cbs_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire
